// ===== rtl/core/ccbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ccbb_pkg;

    // Number of colour classes and the width of a class number.
    localparam int CLASS_COUNT = 5;
    localparam int CLASS_BITS  = 3;
    localparam int LEVEL_BITS  = 8;
    localparam int REG_INDEX_BITS = 3;

    // Class numbers as they appear on the class_id output.
    localparam logic [CLASS_BITS-1:0] CLASS_BLUE   = 3'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_RED    = 3'd1;
    localparam logic [CLASS_BITS-1:0] CLASS_GREEN  = 3'd2;
    localparam logic [CLASS_BITS-1:0] CLASS_YELLOW = 3'd3;
    localparam logic [CLASS_BITS-1:0] CLASS_PURPLE = 3'd4;
    localparam logic [CLASS_BITS-1:0] CLASS_LAST   = CLASS_PURPLE;

    // Configuration register indexes.
    localparam logic [REG_INDEX_BITS-1:0] REG_STRONG        = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_WEAK          = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_YELLOW_BLUE   = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_PURPLE_STRONG = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_PURPLE_GREEN  = 3'd4;

    // Reset values of the thresholds.
    localparam logic [LEVEL_BITS-1:0] STRONG_RESET        = 8'd100;
    localparam logic [LEVEL_BITS-1:0] WEAK_RESET          = 8'd50;
    localparam logic [LEVEL_BITS-1:0] YELLOW_BLUE_RESET   = 8'd20;
    localparam logic [LEVEL_BITS-1:0] PURPLE_STRONG_RESET = 8'd200;
    localparam logic [LEVEL_BITS-1:0] PURPLE_GREEN_RESET  = 8'd150;

    // Entries in the queue between classifier and box tracker.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_CNT_BITS = 2;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] strong_level;
        logic [LEVEL_BITS-1:0] weak_level;
        logic [LEVEL_BITS-1:0] yellow_blue;
        logic [LEVEL_BITS-1:0] purple_strong;
        logic [LEVEL_BITS-1:0] purple_green;
    } thr_t;

    // Handshake between the queue and the box tracker.
    typedef struct packed {
        logic empty;
        logic pop;
    } qctl_t;

    // One bit per class; several classes may match the same pixel.
    function automatic logic [CLASS_COUNT-1:0] classify(
        input logic [LEVEL_BITS-1:0] b,
        input logic [LEVEL_BITS-1:0] g,
        input logic [LEVEL_BITS-1:0] r,
        input thr_t                  t
    );
        logic [CLASS_COUNT-1:0] hit;
        hit = '0;
        hit[CLASS_BLUE]   = (b >= t.strong_level) && (g < t.weak_level)
                            && (r < t.weak_level);
        hit[CLASS_RED]    = (r >= t.strong_level) && (b < t.weak_level)
                            && (g < t.weak_level);
        hit[CLASS_GREEN]  = (g >= t.strong_level) && (b < t.weak_level)
                            && (r < t.weak_level);
        hit[CLASS_YELLOW] = (b < t.yellow_blue) && (g >= t.strong_level)
                            && (r >= t.strong_level);
        hit[CLASS_PURPLE] = (b >= t.purple_strong) && (g < t.purple_green)
                            && (r >= t.purple_strong);
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ccbb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccbb_front #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [ccbb_pkg::LEVEL_BITS-1:0]  blue,
    input  wire logic [ccbb_pkg::LEVEL_BITS-1:0]  green,
    input  wire logic [ccbb_pkg::LEVEL_BITS-1:0]  red,
    input  wire logic [COORD_BITS-1:0]            column,
    input  wire logic [COORD_BITS-1:0]            row,
    input  wire logic                             frame_end,
    input  wire ccbb_pkg::thr_t                   thr,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output logic [ccbb_pkg::CLASS_COUNT+2*COORD_BITS:0] q_data
);
    import ccbb_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic [CLASS_COUNT-1:0] hit_reg;
    logic [COORD_BITS-1:0]  x_reg;
    logic [COORD_BITS-1:0]  y_reg;
    logic                   last_reg;
    logic                   accept;

    // The classified beat waits here until the queue has room.
    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = valid_reg && !q_full;
    assign q_data   = {last_reg, hit_reg, x_reg, y_reg};

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg  <= classify(blue, green, red, thr);
            x_reg    <= column;
            y_reg    <= row;
            last_reg <= frame_end;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ccbb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccbb_queue #(
    parameter int WIDTH = 26
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire ccbb_pkg::qctl_t  ctl_in,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    import ccbb_pkg::*;

    logic [WIDTH-1:0]          slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;
    logic                      do_pop;

    assign full     = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_pop   = ctl_in.pop && !ctl_in.empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ccbb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ccbb_back #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [ccbb_pkg::CLASS_COUNT+2*COORD_BITS:0] q_data,
    input  wire logic                                   q_empty,
    output ccbb_pkg::qctl_t                             qctl,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [ccbb_pkg::CLASS_BITS-1:0]             class_id,
    output logic                                        found,
    output logic [COORD_BITS-1:0]                       left_edge,
    output logic [COORD_BITS-1:0]                       right_edge,
    output logic [COORD_BITS-1:0]                       top_edge,
    output logic [COORD_BITS-1:0]                       bottom_edge,
    output logic [COORD_BITS-1:0]                       centre_column,
    output logic [COORD_BITS-1:0]                       centre_row,
    output logic                                        last_class
);
    import ccbb_pkg::*;

    logic [COORD_BITS-1:0]  left_reg   [CLASS_COUNT];
    logic [COORD_BITS-1:0]  right_reg  [CLASS_COUNT];
    logic [COORD_BITS-1:0]  top_reg    [CLASS_COUNT];
    logic [COORD_BITS-1:0]  bottom_reg [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] seen_reg;

    logic [COORD_BITS-1:0]  left_next   [CLASS_COUNT];
    logic [COORD_BITS-1:0]  right_next  [CLASS_COUNT];
    logic [COORD_BITS-1:0]  top_next    [CLASS_COUNT];
    logic [COORD_BITS-1:0]  bottom_next [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] seen_next;

    // Frozen copy of the finished frame, read out one class per beat.
    logic [COORD_BITS-1:0]  snap_left_reg   [CLASS_COUNT];
    logic [COORD_BITS-1:0]  snap_right_reg  [CLASS_COUNT];
    logic [COORD_BITS-1:0]  snap_top_reg    [CLASS_COUNT];
    logic [COORD_BITS-1:0]  snap_bottom_reg [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] snap_seen_reg;

    logic                   busy_reg;
    logic [CLASS_BITS-1:0]  idx_reg;

    logic                   q_last;
    logic [CLASS_COUNT-1:0] q_hit;
    logic [COORD_BITS-1:0]  q_x;
    logic [COORD_BITS-1:0]  q_y;
    logic                   out_accept;
    logic                   report_free;
    logic                   pop;
    logic [COORD_BITS:0]    col_sum;
    logic [COORD_BITS:0]    row_sum;

    assign {q_last, q_hit, q_x, q_y} = q_data;

    assign out_accept  = busy_reg && !out_stall;
    assign report_free = !busy_reg || (out_accept && idx_reg == CLASS_LAST);
    assign pop         = !q_empty && (!q_last || report_free);
    assign qctl.pop    = pop;
    assign qctl.empty  = q_empty;

    always_comb
    begin
        for (int k = 0; k < CLASS_COUNT; k++)
        begin
            left_next[k]   = left_reg[k];
            right_next[k]  = right_reg[k];
            top_next[k]    = top_reg[k];
            bottom_next[k] = bottom_reg[k];
            seen_next[k]   = seen_reg[k];
            if (q_hit[k])
            begin
                if (q_x < left_reg[k])   left_next[k]   = q_x;
                if (q_x > right_reg[k])  right_next[k]  = q_x;
                if (q_y < top_reg[k])    top_next[k]    = q_y;
                if (q_y > bottom_reg[k]) bottom_next[k] = q_y;
                seen_next[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CLASS_COUNT; k++)
            begin
                left_reg[k]   <= '1;
                right_reg[k]  <= '0;
                top_reg[k]    <= '1;
                bottom_reg[k] <= '0;
            end
            seen_reg <= '0;
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            if (pop && q_last)
            begin
                // The boxes start over for the next frame right away.
                for (int k = 0; k < CLASS_COUNT; k++)
                begin
                    left_reg[k]   <= '1;
                    right_reg[k]  <= '0;
                    top_reg[k]    <= '1;
                    bottom_reg[k] <= '0;
                end
                seen_reg <= '0;
            end
            else if (pop)
            begin
                for (int k = 0; k < CLASS_COUNT; k++)
                begin
                    left_reg[k]   <= left_next[k];
                    right_reg[k]  <= right_next[k];
                    top_reg[k]    <= top_next[k];
                    bottom_reg[k] <= bottom_next[k];
                end
                seen_reg <= seen_next;
            end

            if (pop && q_last)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (out_accept && idx_reg == CLASS_LAST)
            begin
                busy_reg <= 1'b0;
            end
            else if (out_accept)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_last)
        begin
            for (int k = 0; k < CLASS_COUNT; k++)
            begin
                snap_left_reg[k]   <= left_next[k];
                snap_right_reg[k]  <= right_next[k];
                snap_top_reg[k]    <= top_next[k];
                snap_bottom_reg[k] <= bottom_next[k];
            end
            snap_seen_reg <= seen_next;
        end
    end

    assign out_valid   = busy_reg;
    assign class_id    = idx_reg;
    assign last_class  = (idx_reg == CLASS_LAST);
    assign found       = snap_seen_reg[idx_reg];
    assign left_edge   = found ? snap_left_reg[idx_reg]   : '0;
    assign right_edge  = found ? snap_right_reg[idx_reg]  : '0;
    assign top_edge    = found ? snap_top_reg[idx_reg]    : '0;
    assign bottom_edge = found ? snap_bottom_reg[idx_reg] : '0;
    assign col_sum     = {1'b0, left_edge} + {1'b0, right_edge};
    assign row_sum     = {1'b0, top_edge} + {1'b0, bottom_edge};
    assign centre_column = col_sum[COORD_BITS:1];
    assign centre_row    = row_sum[COORD_BITS:1];

endmodule

`default_nettype wire

// ===== rtl/core/color_class_bounding_boxes.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Beat contents
// in        input      in_valid/in_stall    blue, green, red, column, row, frame_end
// out       output     out_valid/out_stall  class_id, found, the box edges and centres,
//                                           last_class
// cfg       input      cfg_write            cfg_index, cfg_data (no handshake back)
//
// One pixel beat is taken per clock while in_stall is low. A pixel sits in the
// classifier register after the edge that takes it, then in the queue, and then
// in the box registers; the first report beat of a frame_end is valid once that
// beat has been popped from the queue.
// A frame_end beat yields five result beats on consecutive cycles while the
// output is not stalled; pixels of the next frame keep flowing meanwhile.
// A second frame_end waits in the queue until the previous report has gone out.
// Reset is asynchronous and active low; it restores the threshold defaults and
// empties all boxes.
module color_class_bounding_boxes #(
    parameter int COORD_BITS = 10
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [ccbb_pkg::LEVEL_BITS-1:0]     blue,
    input  wire logic [ccbb_pkg::LEVEL_BITS-1:0]     green,
    input  wire logic [ccbb_pkg::LEVEL_BITS-1:0]     red,
    input  wire logic [COORD_BITS-1:0]               column,
    input  wire logic [COORD_BITS-1:0]               row,
    input  wire logic                                frame_end,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [ccbb_pkg::CLASS_BITS-1:0]          class_id,
    output logic                                     found,
    output logic [COORD_BITS-1:0]                    left_edge,
    output logic [COORD_BITS-1:0]                    right_edge,
    output logic [COORD_BITS-1:0]                    top_edge,
    output logic [COORD_BITS-1:0]                    bottom_edge,
    output logic [COORD_BITS-1:0]                    centre_column,
    output logic [COORD_BITS-1:0]                    centre_row,
    output logic                                     last_class,
    input  wire logic                                cfg_write,
    input  wire logic [ccbb_pkg::REG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [ccbb_pkg::LEVEL_BITS-1:0]     cfg_data
);
    import ccbb_pkg::*;

    localparam int QW = CLASS_COUNT + 2 * COORD_BITS + 1;

    thr_t            thr_reg;
    logic            q_full;
    logic            q_push;
    logic [QW-1:0]   q_wdata;
    logic [QW-1:0]   q_rdata;
    logic            q_empty;
    qctl_t           qctl;

    // Threshold registers. Writes to indexes past the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.strong_level  <= STRONG_RESET;
            thr_reg.weak_level    <= WEAK_RESET;
            thr_reg.yellow_blue   <= YELLOW_BLUE_RESET;
            thr_reg.purple_strong <= PURPLE_STRONG_RESET;
            thr_reg.purple_green  <= PURPLE_GREEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STRONG:        thr_reg.strong_level  <= cfg_data;
                REG_WEAK:          thr_reg.weak_level    <= cfg_data;
                REG_YELLOW_BLUE:   thr_reg.yellow_blue   <= cfg_data;
                REG_PURPLE_STRONG: thr_reg.purple_strong <= cfg_data;
                REG_PURPLE_GREEN:  thr_reg.purple_green  <= cfg_data;
                default:           thr_reg <= thr_reg;
            endcase
        end
    end

    // Front: takes the pixel and registers its class hits with the position.
    ccbb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .column    (column),
        .row       (row),
        .frame_end (frame_end),
        .thr       (thr_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // Short queue so that a waiting report does not block the classifier.
    ccbb_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .ctl_in    (qctl),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // Back: grows the boxes, freezes them at frame end and reports per class.
    ccbb_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_rdata),
        .q_empty       (q_empty),
        .qctl          (qctl),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .class_id      (class_id),
        .found         (found),
        .left_edge     (left_edge),
        .right_edge    (right_edge),
        .top_edge      (top_edge),
        .bottom_edge   (bottom_edge),
        .centre_column (centre_column),
        .centre_row    (centre_row),
        .last_class    (last_class)
    );

    // A report beat that is not the last one is followed by the next class.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_class
        |=> out_valid && class_id == $past(class_id) + 3'd1)
        else $error("report sequence broken");

    // A class that was not found reports an empty box.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> left_edge == '0 && right_edge == '0
                                && top_edge == '0 && bottom_edge == '0)
        else $error("empty class with nonzero box");

    // A found box is never inverted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> left_edge <= right_edge && top_edge <= bottom_edge)
        else $error("inverted box");

    // The queue never overflows: the front holds its beat while it is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");

endmodule

`default_nettype wire
